[rtl/assert_macros.svh]
// Assertion macros of the DPD pair force core, used by its queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/dpf_pkg.sv]
// Types, constants and helper functions of the DPD pair force core.
package dpf_pkg;

  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_A0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAMMA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIGMA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ISDT  = 3'd4;

  localparam logic [31:0] RST_A0    = 32'd1638400;
  localparam logic [31:0] RST_GAMMA = 32'd294912;
  localparam logic [31:0] RST_SIGMA = 32'd196608;
  localparam logic [31:0] RST_CUT   = 32'd65536;
  localparam logic [31:0] RST_ISDT  = 32'd926819;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIV_W       = 85;

  localparam logic [60:0] CAP60 = 61'h1000000000000000;
  localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MIN48 = 48'h8000_0000_0000;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] dvx;
    logic signed [31:0] dvy;
    logic signed [31:0] dvz;
    logic signed [15:0] noise_sample;
    logic [15:0]        special_factor;
    logic               last_neighbor;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] pair_fx;
    logic signed [47:0] pair_fy;
    logic signed [47:0] pair_fz;
    logic signed [47:0] pair_scalar;
    logic signed [47:0] pair_energy;
    logic               in_range;
    logic signed [47:0] atom_fx;
    logic signed [47:0] atom_fy;
    logic signed [47:0] atom_fz;
    logic               atom_done;
  } out_item_t;

  typedef struct packed {
    in_item_t    item;
    logic [63:0] rsq;
    logic        inr;
  } q_entry_t;

  typedef struct packed {
    logic        start;
    logic [5:0]  sh;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
    logic [60:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [1:0] {FR_IDLE, FR_SQUARE, FR_PUSH} fr_state_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SQRT, BK_DIV_WD, BK_DIV_U, BK_MUL, BK_DIV_SC, BK_OUT
  } bk_state_t;

  typedef enum logic [4:0] {
    MS_DOT0, MS_DOT1, MS_DOT2, MS_WD2, MS_CONS, MS_DRAG_G, MS_DRAG,
    MS_NOISE_S, MS_NOISE_T, MS_NOISE, MS_FM, MS_PF0, MS_PF1, MS_PF2,
    MS_EN_A, MS_EN_W, MS_EN
  } mul_step_t;

  // magnitude of a 32-bit two's complement value
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // apply sign to a magnitude and saturate to 48 bits
  function automatic logic [47:0] sat48_sm(input logic [60:0] m, input logic neg);
    logic [47:0] r;
    if (neg) begin
      if (m > {13'd0, MIN48}) r = MIN48;
      else r = ~m[47:0] + 48'd1;
    end else begin
      if (m > {13'd0, MAX48}) r = MAX48;
      else r = m[47:0];
    end
    return r;
  endfunction

  // saturating 48-bit signed add
  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    logic [47:0] r;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) r = s[48] ? MIN48 : MAX48;
    else r = s[47:0];
    return r;
  endfunction

endpackage

[rtl/dpf_queue.sv]
// Short queue between the classifying front end and the force back end.
`include "assert_macros.svh"
module dpf_queue #(
  parameter int unsigned DEPTH = dpf_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dpf_pkg::q_entry_t wdata,
  input  logic              pop,
  output dpf_pkg::q_entry_t rdata,
  output logic              full,
  output logic              empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dpf_pkg::q_entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst_n, push && full, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty, "pop from empty queue")
  `ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + CW'(1), "count did not rise")
endmodule

[rtl/dpf_front.sv]
// Front end: takes pair beats, forms the squared distance and classifies range.
module dpf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dpf_pkg::in_item_t in_data,
  input  logic [31:0]       cut,
  input  logic              q_full,
  output logic              q_push,
  output dpf_pkg::q_entry_t q_wdata
);
  dpf_pkg::fr_state_t state_r, state_nxt;
  dpf_pkg::in_item_t  item_r;
  logic [1:0]  k_r;
  logic [63:0] acc_r;
  logic [63:0] cutsq_r;
  logic [31:0] dmag;
  logic [63:0] sq;

  // pick one coordinate per cycle
  always_comb begin
    unique case (k_r)
      2'd0:    dmag = dpf_pkg::mag32(item_r.dx);
      2'd1:    dmag = dpf_pkg::mag32(item_r.dy);
      2'd2:    dmag = dpf_pkg::mag32(item_r.dz);
      default: dmag = 32'd0;
    endcase
  end
  assign sq = dmag * dmag;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpf_pkg::FR_IDLE:   if (in_valid) state_nxt = dpf_pkg::FR_SQUARE;
      dpf_pkg::FR_SQUARE: if (k_r == 2'd2) state_nxt = dpf_pkg::FR_PUSH;
      dpf_pkg::FR_PUSH:   if (!q_full) state_nxt = dpf_pkg::FR_IDLE;
      default:            state_nxt = dpf_pkg::FR_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready = (state_r == dpf_pkg::FR_IDLE);
    q_push   = (state_r == dpf_pkg::FR_PUSH) && !q_full;
  end

  // in range when squared distance is non-zero and below (cut << 8)^2
  always_comb begin
    q_wdata.item = item_r;
    q_wdata.rsq  = acc_r;
    q_wdata.inr  = (acc_r != 64'd0) && ({16'd0, acc_r} < {cutsq_r, 16'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dpf_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture beat and accumulate squares
  always_ff @(posedge clk) begin
    cutsq_r <= cut * cut;
    if (in_valid && in_ready) begin
      item_r <= in_data;
      k_r    <= 2'd0;
      acc_r  <= 64'd0;
    end else if (state_r == dpf_pkg::FR_SQUARE) begin
      acc_r <= acc_r + sq;
      k_r   <= k_r + 2'd1;
    end
  end
endmodule

[rtl/dpf_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module dpf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dpf_pkg::div_req_t req,
  output dpf_pkg::div_rsp_t rsp
);
  localparam int unsigned NW = dpf_pkg::DIV_W;
  localparam int unsigned CW = $clog2(NW);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   rem_r, dvs_r;
  logic [NW-1:0] quo_r;
  logic [32:0]   trial, diff;
  logic          ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(NW - 1));
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(NW - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  // shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= 32'd0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[NW-2:0], ge};
      cnt_r <= cnt_r + CW'(1);
    end
  end
endmodule

[rtl/dpf_mul.sv]
// 64 by 64 multiplier over four 32 by 32 partial products, then shift and cap.
module dpf_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  dpf_pkg::mul_req_t req,
  output dpf_pkg::mul_rsp_t rsp
);
  logic         busy_r, done_r;
  logic [1:0]   idx_r;
  logic [63:0]  a_r, b_r;
  logic [5:0]   sh_r;
  logic [127:0] acc_r, part, shr;
  logic [31:0]  ai, bj;
  logic [63:0]  pp;

  assign ai = idx_r[1] ? a_r[63:32] : a_r[31:0];
  assign bj = idx_r[0] ? b_r[63:32] : b_r[31:0];
  assign pp = ai * bj;

  // place partial product by its weight
  always_comb begin
    unique case ({1'b0, idx_r[1]} + {1'b0, idx_r[0]})
      2'd0:    part = {64'd0, pp};
      2'd1:    part = {32'd0, pp, 32'd0};
      default: part = {pp, 64'd0};
    endcase
  end

  // truncate by the shift and cap at 2^60
  assign shr      = acc_r >> sh_r;
  assign rsp.done = done_r;
  assign rsp.prod = acc_r[63:0];
  assign rsp.res  = ((|shr[127:61]) || (shr[60:0] > dpf_pkg::CAP60)) ?
                    dpf_pkg::CAP60 : shr[60:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (idx_r == 2'd3);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (idx_r == 2'd3)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      sh_r  <= req.sh;
      acc_r <= 128'd0;
      idx_r <= 2'd0;
    end else if (busy_r) begin
      acc_r <= acc_r + part;
      idx_r <= idx_r + 2'd1;
    end
  end
endmodule

[rtl/dpf_back.sv]
// Back end: square root, divisions and products of one in-range pair, then sums and result.
module dpf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  dpf_pkg::q_entry_t  q_rdata,
  input  logic [31:0]        a0,
  input  logic [31:0]        gamma,
  input  logic [31:0]        sigma,
  input  logic [31:0]        cut,
  input  logic [31:0]        isdt,
  output logic               out_valid,
  input  logic               out_ready,
  output dpf_pkg::out_item_t out_data
);
  dpf_pkg::bk_state_t state_r, state_nxt;
  dpf_pkg::mul_step_t mstep_r, mstep_nxt;
  dpf_pkg::q_entry_t  ent_r, ent_nxt;
  dpf_pkg::out_item_t out_r, out_nxt;
  dpf_pkg::mul_req_t  mreq;
  dpf_pkg::mul_rsp_t  mrsp;
  dpf_pkg::div_req_t  dreq;
  dpf_pkg::div_rsp_t  drsp;

  logic        issued_r, issued_nxt, out_valid_r, out_valid_nxt;
  logic [63:0] x_r, x_nxt, ra_r, ra_nxt, bit_r, bit_nxt, trial;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [1:0]  k_r, k_nxt, lane;
  logic [32:0] wd_r, wd_nxt;
  logic [30:0] umag_r [3];
  logic [30:0] umag_nxt [3];
  logic [2:0]  uneg_r, uneg_nxt;
  logic [63:0] dot_r, dot_nxt, dotr_mag, f, fmag, pneg_prod;
  logic [60:0] wd2_r, wd2_nxt, cons_r, cons_nxt, drag_r, drag_nxt;
  logic [60:0] noise_r, noise_nxt, t1_r, t1_nxt, fm_r, fm_nxt, en_r, en_nxt, qcap;
  logic        fneg_r, fneg_nxt;
  logic [47:0] pf_r [3];
  logic [47:0] pf_nxt [3];
  logic [47:0] pfg [3];
  logic [47:0] newsum [3];
  logic [47:0] sum_r [3];
  logic [47:0] sum_nxt [3];
  logic [47:0] scalar_r, scalar_nxt;
  logic [31:0] d_sel [3];
  logic [31:0] dv_sel [3];
  logic [31:0] rmag32;
  logic [15:0] rmag;
  logic        slot_free, unit_done;

  dpf_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  dpf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign d_sel[0]  = ent_r.item.dx;
  assign d_sel[1]  = ent_r.item.dy;
  assign d_sel[2]  = ent_r.item.dz;
  assign dv_sel[0] = ent_r.item.dvx;
  assign dv_sel[1] = ent_r.item.dvy;
  assign dv_sel[2] = ent_r.item.dvz;
  assign rmag32    = dpf_pkg::mag32({{16{ent_r.item.noise_sample[15]}},
                                     ent_r.item.noise_sample});
  assign rmag      = rmag32[15:0];
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign trial     = ra_r + bit_r;

  // dot product truncated toward zero by 2^22
  assign dotr_mag = (dot_r[63] ? (~dot_r + 64'd1) : dot_r) >> 22;

  // scalar force: conservative minus drag plus random term
  always_comb begin
    f = {3'd0, cons_r}
        - (dot_r[63] ? (~{3'd0, drag_r} + 64'd1) : {3'd0, drag_r})
        + (ent_r.item.noise_sample[15] ? (~{3'd0, noise_r} + 64'd1) : {3'd0, noise_r});
    fmag = f[63] ? (~f + 64'd1) : f;
  end

  // lane of the dot and force steps
  always_comb begin
    unique case (mstep_r)
      dpf_pkg::MS_DOT1, dpf_pkg::MS_PF1: lane = 2'd1;
      dpf_pkg::MS_DOT2, dpf_pkg::MS_PF2: lane = 2'd2;
      default:                           lane = 2'd0;
    endcase
  end

  // multiplier operands per step
  always_comb begin
    mreq.start = (state_r == dpf_pkg::BK_MUL) && !issued_r;
    mreq.a     = 64'd0;
    mreq.b     = 64'd0;
    mreq.sh    = 6'd0;
    unique case (mstep_r)
      dpf_pkg::MS_DOT0, dpf_pkg::MS_DOT1, dpf_pkg::MS_DOT2: begin
        mreq.a = {33'd0, umag_r[lane]};
        mreq.b = {32'd0, dpf_pkg::mag32(dv_sel[lane])};
      end
      dpf_pkg::MS_WD2: begin
        mreq.a = {31'd0, wd_r}; mreq.b = {31'd0, wd_r}; mreq.sh = 6'd32;
      end
      dpf_pkg::MS_CONS: begin
        mreq.a = {32'd0, a0}; mreq.b = {31'd0, wd_r}; mreq.sh = 6'd16;
      end
      dpf_pkg::MS_DRAG_G: begin
        mreq.a = {32'd0, gamma}; mreq.b = {3'd0, wd2_r}; mreq.sh = 6'd32;
      end
      dpf_pkg::MS_DRAG: begin
        mreq.a = {3'd0, t1_r}; mreq.b = dotr_mag; mreq.sh = 6'd16;
      end
      dpf_pkg::MS_NOISE_S: begin
        mreq.a = {32'd0, sigma}; mreq.b = {31'd0, wd_r}; mreq.sh = 6'd32;
      end
      dpf_pkg::MS_NOISE_T: begin
        mreq.a = {3'd0, t1_r}; mreq.b = {32'd0, isdt}; mreq.sh = 6'd16;
      end
      dpf_pkg::MS_NOISE: begin
        mreq.a = {3'd0, t1_r}; mreq.b = {44'd0, rmag, 4'd0};
      end
      dpf_pkg::MS_FM: begin
        mreq.a = fmag; mreq.b = {48'd0, ent_r.item.special_factor}; mreq.sh = 6'd15;
      end
      dpf_pkg::MS_PF0, dpf_pkg::MS_PF1, dpf_pkg::MS_PF2: begin
        mreq.a = {3'd0, fm_r}; mreq.b = {33'd0, umag_r[lane]}; mreq.sh = 6'd30;
      end
      dpf_pkg::MS_EN_A: begin
        mreq.a = {32'd0, a0}; mreq.b = {32'd0, cut}; mreq.sh = 6'd1;
      end
      dpf_pkg::MS_EN_W: begin
        mreq.a = {3'd0, t1_r}; mreq.b = {3'd0, wd2_r}; mreq.sh = 6'd32;
      end
      dpf_pkg::MS_EN: begin
        mreq.a = {3'd0, t1_r}; mreq.b = {48'd0, ent_r.item.special_factor}; mreq.sh = 6'd15;
      end
      default: mreq.sh = 6'd0;
    endcase
  end

  // divider operands per state
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = ra_r[31:0];
    unique case (state_r)
      dpf_pkg::BK_DIV_WD: begin
        dreq.start    = !issued_r;
        dreq.dividend = {29'd0, ra_r[31:0], 24'd0};
        dreq.divisor  = cut;
      end
      dpf_pkg::BK_DIV_U: begin
        dreq.start    = !issued_r;
        dreq.dividend = {23'd0, dpf_pkg::mag32(d_sel[k_r]), 30'd0};
      end
      dpf_pkg::BK_DIV_SC: begin
        dreq.start    = !issued_r;
        dreq.dividend = {fm_r, 24'd0};
      end
      default: dreq.start = 1'b0;
    endcase
  end

  assign unit_done = (state_r == dpf_pkg::BK_MUL) ? mrsp.done : drsp.done;
  assign q_pop     = (state_r == dpf_pkg::BK_IDLE) && !q_empty;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpf_pkg::BK_IDLE:
        if (!q_empty) state_nxt = q_rdata.inr ? dpf_pkg::BK_SQRT : dpf_pkg::BK_OUT;
      dpf_pkg::BK_SQRT:
        if (cnt_r == 5'd31) state_nxt = dpf_pkg::BK_DIV_WD;
      dpf_pkg::BK_DIV_WD:
        if (unit_done) state_nxt = dpf_pkg::BK_DIV_U;
      dpf_pkg::BK_DIV_U:
        if (unit_done && (k_r == 2'd2)) state_nxt = dpf_pkg::BK_MUL;
      dpf_pkg::BK_MUL:
        if (unit_done && (mstep_r == dpf_pkg::MS_EN)) state_nxt = dpf_pkg::BK_DIV_SC;
      dpf_pkg::BK_DIV_SC:
        if (unit_done) state_nxt = dpf_pkg::BK_OUT;
      dpf_pkg::BK_OUT:
        if (slot_free) state_nxt = dpf_pkg::BK_IDLE;
      default: state_nxt = dpf_pkg::BK_IDLE;
    endcase
  end

  // gated pair forces and running sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pfg[i]    = ent_r.inr ? pf_r[i] : 48'd0;
      newsum[i] = dpf_pkg::sat_add48(sum_r[i], pfg[i]);
    end
    pneg_prod = ~mrsp.prod + 64'd1;
    qcap      = (drsp.quo > {24'd0, dpf_pkg::CAP60}) ? dpf_pkg::CAP60 : drsp.quo[60:0];
  end

  // datapath next values
  always_comb begin
    ent_nxt = ent_r; x_nxt = x_r; ra_nxt = ra_r; bit_nxt = bit_r; cnt_nxt = cnt_r;
    k_nxt = k_r; mstep_nxt = mstep_r; wd_nxt = wd_r; uneg_nxt = uneg_r;
    dot_nxt = dot_r; wd2_nxt = wd2_r; cons_nxt = cons_r; drag_nxt = drag_r;
    noise_nxt = noise_r; t1_nxt = t1_r; fm_nxt = fm_r; fneg_nxt = fneg_r;
    en_nxt = en_r; scalar_nxt = scalar_r; out_nxt = out_r;
    umag_nxt = umag_r; pf_nxt = pf_r; sum_nxt = sum_r;
    issued_nxt = issued_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if ((mreq.start || dreq.start)) issued_nxt = 1'b1;
    if (unit_done) issued_nxt = 1'b0;
    unique case (state_r)
      dpf_pkg::BK_IDLE: begin
        if (!q_empty) begin
          ent_nxt = q_rdata; x_nxt = q_rdata.rsq; ra_nxt = 64'd0;
          bit_nxt = 64'h4000_0000_0000_0000; cnt_nxt = 5'd0;
          dot_nxt = 64'd0; k_nxt = 2'd0; mstep_nxt = dpf_pkg::MS_DOT0;
        end
      end
      // one result bit per step of the square root, two radicand bits consumed
      dpf_pkg::BK_SQRT: begin
        if (x_r >= trial) begin
          x_nxt  = x_r - trial;
          ra_nxt = (ra_r >> 1) + bit_r;
        end else begin
          ra_nxt = ra_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
      end
      dpf_pkg::BK_DIV_WD: begin
        if (unit_done) wd_nxt = 33'h1_0000_0000 - {1'b0, drsp.quo[31:0]};
      end
      dpf_pkg::BK_DIV_U: begin
        if (unit_done) begin
          umag_nxt[k_r] = drsp.quo[30:0];
          uneg_nxt[k_r] = d_sel[k_r][31];
          k_nxt = k_r + 2'd1;
        end
      end
      dpf_pkg::BK_MUL: begin
        if (unit_done) begin
          mstep_nxt = dpf_pkg::mul_step_t'(mstep_r + 5'd1);
          unique case (mstep_r)
            dpf_pkg::MS_DOT0, dpf_pkg::MS_DOT1, dpf_pkg::MS_DOT2:
              dot_nxt = dot_r + ((uneg_r[lane] ^ dv_sel[lane][31]) ? pneg_prod : mrsp.prod);
            dpf_pkg::MS_WD2:  wd2_nxt = mrsp.res;
            dpf_pkg::MS_CONS: cons_nxt = mrsp.res;
            dpf_pkg::MS_DRAG: drag_nxt = mrsp.res;
            dpf_pkg::MS_DRAG_G, dpf_pkg::MS_NOISE_S, dpf_pkg::MS_NOISE_T,
            dpf_pkg::MS_EN_A, dpf_pkg::MS_EN_W:
              t1_nxt = mrsp.res;
            dpf_pkg::MS_NOISE: noise_nxt = mrsp.res;
            dpf_pkg::MS_FM: begin
              fm_nxt = mrsp.res; fneg_nxt = f[63];
            end
            dpf_pkg::MS_PF0, dpf_pkg::MS_PF1, dpf_pkg::MS_PF2:
              pf_nxt[lane] = dpf_pkg::sat48_sm(mrsp.res, fneg_r ^ uneg_r[lane]);
            dpf_pkg::MS_EN: en_nxt = mrsp.res;
            default: en_nxt = en_r;
          endcase
        end
      end
      dpf_pkg::BK_DIV_SC: begin
        if (unit_done) scalar_nxt = dpf_pkg::sat48_sm(qcap, fneg_r);
      end
      // hand over result, fold the pair into the atom sums
      dpf_pkg::BK_OUT: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.pair_fx     = pfg[0];
          out_nxt.pair_fy     = pfg[1];
          out_nxt.pair_fz     = pfg[2];
          out_nxt.pair_scalar = ent_r.inr ? scalar_r : 48'd0;
          out_nxt.pair_energy = ent_r.inr ? dpf_pkg::sat48_sm(en_r, 1'b0) : 48'd0;
          out_nxt.in_range    = ent_r.inr;
          out_nxt.atom_done   = ent_r.item.last_neighbor;
          if (ent_r.item.last_neighbor) begin
            out_nxt.atom_fx = newsum[0];
            out_nxt.atom_fy = newsum[1];
            out_nxt.atom_fz = newsum[2];
            for (int i = 0; i < 3; i++) sum_nxt[i] = 48'd0;
          end else begin
            out_nxt.atom_fx = 48'd0;
            out_nxt.atom_fy = 48'd0;
            out_nxt.atom_fz = 48'd0;
            sum_nxt = newsum;
          end
        end
      end
      default: issued_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpf_pkg::BK_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) sum_r[i] <= 48'd0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt; x_r <= x_nxt; ra_r <= ra_nxt; bit_r <= bit_nxt; cnt_r <= cnt_nxt;
    k_r <= k_nxt; mstep_r <= mstep_nxt; wd_r <= wd_nxt; uneg_r <= uneg_nxt;
    umag_r <= umag_nxt; dot_r <= dot_nxt; wd2_r <= wd2_nxt; cons_r <= cons_nxt;
    drag_r <= drag_nxt; noise_r <= noise_nxt; t1_r <= t1_nxt; fm_r <= fm_nxt;
    fneg_r <= fneg_nxt; en_r <= en_nxt; pf_r <= pf_nxt; scalar_r <= scalar_nxt;
    out_r <= out_nxt;
  end
endmodule

[rtl/dpd_pair_force_core.sv]
// Top level of the DPD pair force core: configuration registers and the three parts.
// The back end takes a new pair from the queue only once it is through with the last.
// An in-range pair passes the 32-step square root, five 85-step divisions on the shared
// radix-2 divider and the multiplier steps. Out-of-range pairs are limited by the front
// end, which squares three coordinates and waits on a full queue before its next beat.
// Reset (rst_n low, synchronous) empties the queue, clears the atom sums and
// loads the register defaults; no clearing pass follows.
module dpd_pair_force_core #(
  parameter int unsigned QUEUE_DEPTH = dpf_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dpf_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dpf_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [dpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpf_pkg::CFG_W-1:0]      cfg_wdata
);
  logic [31:0] a0_r, gamma_r, sigma_r, cut_r, isdt_r;
  logic q_push, q_pop, q_full, q_empty;
  dpf_pkg::q_entry_t q_wdata, q_rdata;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_r    <= dpf_pkg::RST_A0;
      gamma_r <= dpf_pkg::RST_GAMMA;
      sigma_r <= dpf_pkg::RST_SIGMA;
      cut_r   <= dpf_pkg::RST_CUT;
      isdt_r  <= dpf_pkg::RST_ISDT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpf_pkg::CFG_IDX_A0:    a0_r    <= cfg_wdata;
        dpf_pkg::CFG_IDX_GAMMA: gamma_r <= cfg_wdata;
        dpf_pkg::CFG_IDX_SIGMA: sigma_r <= cfg_wdata;
        dpf_pkg::CFG_IDX_CUT:   cut_r   <= cfg_wdata;
        dpf_pkg::CFG_IDX_ISDT:  isdt_r  <= cfg_wdata;
        default:                isdt_r  <= isdt_r;
      endcase
    end
  end

  dpf_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .cut(cut_r), .q_full(q_full), .q_push(q_push),
    .q_wdata(q_wdata)
  );

  dpf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  dpf_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_pop(q_pop), .q_rdata(q_rdata),
    .a0(a0_r), .gamma(gamma_r), .sigma(sigma_r), .cut(cut_r), .isdt(isdt_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
